// ----- hdl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block: default widths and
// the reset value of the modulus register.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Default operand widths
    parameter int MOD_WIDTH_DEF = 31;
    parameter int EXP_WIDTH_DEF = 63;

    // Modulus after reset; taken in its low MOD_WIDTH bits
    parameter logic [30:0] MODULUS_RESET = 31'd1000000007;

endpackage

`default_nettype wire

// ----- hdl/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// mexp_mulmod
// Shared modular multiplier: (a * b) mod m by interleaved shift-and-add,
// one bit of b per cycle from the MSB down. Operand a must be below m.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [MOD_WIDTH-1:0] i_a,
    input  wire logic [MOD_WIDTH-1:0] i_b,
    input  wire logic [MOD_WIDTH:0]   i_m,
    output logic                      o_done,
    output logic [MOD_WIDTH-1:0]      o_result
);

    localparam int CW = $clog2(MOD_WIDTH);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [MOD_WIDTH-1:0] r_r;
    logic [MOD_WIDTH-1:0] r_a;
    logic [MOD_WIDTH-1:0] r_b;
    logic [MOD_WIDTH:0]   r_m;

    logic [MOD_WIDTH+1:0] w_m;
    logic [MOD_WIDTH+1:0] w_dbl;
    logic [MOD_WIDTH+1:0] w_dbl_red;
    logic [MOD_WIDTH+1:0] w_sum;
    logic [MOD_WIDTH+1:0] w_sum_red;

    // One step: r = (2r mod m + bit * a) mod m; both partial values stay below 2m
    always_comb begin
        w_m       = {1'b0, r_m};
        w_dbl     = {1'b0, r_r, 1'b0};
        w_dbl_red = (w_dbl >= w_m) ? (w_dbl - w_m) : w_dbl;
        w_sum     = w_dbl_red + (r_b[MOD_WIDTH-1] ? {2'b00, r_a} : '0);
        w_sum_red = (w_sum >= w_m) ? (w_sum - w_m) : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MOD_WIDTH - 1);
                r_r    <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
            end else if (r_busy) begin
                r_r <= w_sum_red[MOD_WIDTH-1:0];
                r_b <= {r_b[MOD_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

`default_nettype wire

// ----- hdl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ** exponent mod modulus by binary square-and-multiply on one shared
// shift-and-add modular multiplier, driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+---------------------------
//  input   | in        | i_valid / o_stall          | i_base, i_exponent
//  output  | out       | o_valid / i_stall          | o_power_mod
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_modulus
//
//  Work: an item with exponent e > 0 uses the shared multiplier for one
//  multiply to reduce the base, one per set bit and one squaring per bit
//  below the top one, with one decision step per exponent bit. A zero
//  exponent skips the multiplier.
//  Reset: synchronous, active low; clears the sequencer and output valid and
//  loads the modulus with its default.
//  Stalls: o_stall is high while an item is in work; a finished result waits
//  in the output register, and the next item is taken meanwhile.
//
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input transfer
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [MOD_WIDTH-1:0] i_base,
    input  wire logic [EXP_WIDTH-1:0] i_exponent,
    // output transfer
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [MOD_WIDTH-1:0]      o_power_mod,
    // configuration write
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [MOD_WIDTH-1:0] i_cfg_modulus
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MUL,
        S_SQR,
        S_FIN
    } t_state;

    t_state               r_state,     n_state;
    logic [MOD_WIDTH-1:0] r_modulus,   n_modulus;
    logic [MOD_WIDTH-1:0] r_x,         n_x;
    logic [MOD_WIDTH-1:0] r_acc,       n_acc;
    logic [EXP_WIDTH-1:0] r_exp,       n_exp;
    logic                 r_start,     n_start;
    logic [MOD_WIDTH-1:0] r_op_a,      n_op_a;
    logic [MOD_WIDTH-1:0] r_op_b,      n_op_b;
    logic                 r_out_valid, n_out_valid;
    logic [MOD_WIDTH-1:0] r_out,       n_out;

    logic [MOD_WIDTH:0]   w_m_eff;
    logic [MOD_WIDTH-1:0] w_one_mod;
    logic                 w_mm_done;
    logic [MOD_WIDTH-1:0] w_mm_result;

    // A zero modulus register means 2^MOD_WIDTH: arithmetic wraps at the width
    assign w_m_eff   = {(r_modulus == '0), r_modulus};
    // 1 mod m; only a modulus of one brings it to zero
    assign w_one_mod = (r_modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

    mexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_a      (r_op_a),
        .i_b      (r_op_b),
        .i_m      (w_m_eff),
        .o_done   (w_mm_done),
        .o_result (w_mm_result)
    );

    always_comb begin
        n_state     = r_state;
        n_modulus   = r_modulus;
        n_x         = r_x;
        n_acc       = r_acc;
        n_exp       = r_exp;
        n_start     = 1'b0;
        n_op_a      = r_op_a;
        n_op_b      = r_op_b;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // The user must write configuration only while idle; the block does not enforce it
        if (i_cfg_valid) begin
            n_modulus = i_cfg_modulus;
        end

        // Drop the held result once the consumer takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_exp = i_exponent;
                    n_x   = i_base;
                    if (i_exponent == '0) begin
                        // No reduction step: result is 1 for any modulus
                        n_acc   = MOD_WIDTH'(1);
                        n_state = S_FIN;
                    end else begin
                        // Reduce the base first: x = (1 mod m) * base mod m
                        n_acc   = w_one_mod;
                        n_start = 1'b1;
                        n_op_a  = w_one_mod;
                        n_op_b  = i_base;
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (w_mm_done) begin
                    n_x     = w_mm_result;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                // Exponent is nonzero here
                n_start = 1'b1;
                if (r_exp[0]) begin
                    n_op_a  = r_acc;
                    n_op_b  = r_x;
                    n_state = S_MUL;
                end else begin
                    n_op_a  = r_x;
                    n_op_b  = r_x;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (w_mm_done) begin
                    n_acc = w_mm_result;
                    if (r_exp[EXP_WIDTH-1:1] == '0) begin
                        // Top bit done: the last squaring would not be used
                        n_state = S_FIN;
                    end else begin
                        n_start = 1'b1;
                        n_op_a  = r_x;
                        n_op_b  = r_x;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (w_mm_done) begin
                    n_x   = w_mm_result;
                    n_exp = {1'b0, r_exp[EXP_WIDTH-1:1]};
                    if (r_exp[EXP_WIDTH-1:1] == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= MODULUS_RESET[MOD_WIDTH-1:0];
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_modulus   <= n_modulus;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
            r_acc       <= n_acc;
            r_exp       <= n_exp;
            r_op_a      <= n_op_a;
            r_op_b      <= n_op_b;
            r_out       <= n_out;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_power_mod = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- hdl/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_stall,
    input wire logic [EXP_WIDTH-1:0] i_exponent,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic [MOD_WIDTH-1:0] o_power_mod
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_power_mod)))
        else $error("result changed or vanished while stalled");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block ready right after a transfer in");

    // A new result only appears at the end of an item in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an item in work");

    // Reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

    // Zero exponent skips the multiplier: the sequencer goes straight to S_FIN and
    // is ready again after it unless the held result was still stalled in between
    a_zero_exp_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_exponent == '0))
            |=> ##1 (!o_stall || $past(o_valid && i_stall)))
        else $error("zero exponent item did not finish promptly");

endmodule

bind modular_exponentiation mexp_checker #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
) u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_exponent  (i_exponent),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_power_mod (o_power_mod)
);

`default_nettype wire

// ----- dv/mexp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mexp_checker
// Watches the input, output and configuration channels of the modular
// exponentiation block, predicts base ** exponent mod modulus for every input
// transfer and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_mexp_checker
    import mexp_pkg::*;
#(
    parameter int MOD_W = MOD_WIDTH_DEF,
    parameter int EXP_W = EXP_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             o_stall,
    input  logic [MOD_W-1:0] i_base,
    input  logic [EXP_W-1:0] i_exponent,
    input  logic             o_valid,
    input  logic             i_stall,
    input  logic [MOD_W-1:0] o_power_mod,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [MOD_W-1:0] i_cfg_modulus,
    // mismatches plus predictions still waiting for their result
    output int               fail_count
);

    logic [MOD_W-1:0] modulus_copy = MODULUS_RESET[MOD_W-1:0];
    logic [MOD_W-1:0] pending_powers[$];
    logic [MOD_W-1:0] want;
    logic [MOD_W-1:0] predicted;
    int               mismatches = 0;

    // A zero modulus register means arithmetic wraps at 2 ** MOD_W.
    function automatic logic [MOD_W-1:0] power_mod_of(
        input logic [MOD_W-1:0] base,
        input logic [EXP_W-1:0] expo,
        input logic [MOD_W-1:0] mod_reg
    );
        logic [63:0]      m;
        logic [63:0]      x;
        logic [63:0]      acc;
        logic [EXP_W-1:0] e;
        m   = (mod_reg == '0) ? (64'd1 << MOD_W) : 64'(mod_reg);
        x   = 64'(base);
        e   = expo;
        acc = 64'd1;
        while (e != '0) begin
            if (e[0]) begin
                acc = (acc * x) % m;
            end
            x = (x * x) % m;
            e = e >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_copy = MODULUS_RESET[MOD_W-1:0];
            pending_powers.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                modulus_copy = i_cfg_modulus;
            end
            if (i_valid && !o_stall) begin
                predicted      = power_mod_of(i_base, i_exponent, modulus_copy);
                pending_powers = {pending_powers, predicted};
            end
            if (o_valid && !i_stall) begin
                if (pending_powers.size() == 0) begin
                    $error("power_mod: expected none, actual %0d", o_power_mod);
                    mismatches++;
                end else begin
                    want = pending_powers.pop_front();
                    if (o_power_mod !== want) begin
                        $error("power_mod: expected %0d, actual %0d", want, o_power_mod);
                        mismatches++;
                    end
                end
            end
        end
        fail_count = mismatches + pending_powers.size();
    end

endmodule

// ----- dv/tb_modular_exponentiation.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Drives base/exponent pairs into the modular exponentiation block under a
// series of modulus settings (reset value, extremes, wrap-around, random) and
// lets a checker compare every result with its own square-and-multiply model.
// Both channels idle at random; one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int MOD_W = MOD_WIDTH_DEF;
    localparam int EXP_W = EXP_WIDTH_DEF;

    // Longest quiet stretch tolerated: well above both a full-width exponent
    // and the pressure hold-off, which leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 2000;
    localparam int FIRST_ITEMS    = 300;
    localparam int PHASE_ITEMS    = 175;
    localparam int NUM_SETTINGS   = 7;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [MOD_W-1:0] i_base;
    logic [EXP_W-1:0] i_exponent;
    logic             o_valid;
    logic             i_stall;
    logic [MOD_W-1:0] o_power_mod;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [MOD_W-1:0] i_cfg_modulus;

    int               fail_count;
    int               sent = 0;
    int               rcvd = 0;
    int               idle_cycles = 0;
    logic [MOD_W-1:0] cur_modulus;
    logic [MOD_W-1:0] settings[NUM_SETTINGS];
    bit               steady_tx = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    modular_exponentiation #(
        .MOD_WIDTH(MOD_W),
        .EXP_WIDTH(EXP_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_base       (i_base),
        .i_exponent   (i_exponent),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_power_mod  (o_power_mod),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_modulus(i_cfg_modulus)
    );

    tb_mexp_checker #(
        .MOD_W(MOD_W),
        .EXP_W(EXP_W)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_base       (i_base),
        .i_exponent   (i_exponent),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_power_mod  (o_power_mod),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_modulus(i_cfg_modulus),
        .fail_count   (fail_count)
    );

    // Idle stretch length: mostly a few cycles, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned draw;
        draw = $urandom_range(0, 99);
        if (draw < 75) begin
            return $urandom_range(1, 3);
        end
        if (draw < 95) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 100);
    endfunction

    // Bases: extremes and values tied to the modulus, otherwise full random.
    function automatic logic [MOD_W-1:0] pick_base();
        logic [31:0]  raw;
        int unsigned  sel;
        raw = $urandom();
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2: return MOD_W'(1);
            3: return cur_modulus - MOD_W'(1);
            4: return cur_modulus;
            default: return raw[MOD_W-1:0];
        endcase
    endfunction

    // Keep most exponents short so the run stays fast; a few use all bits.
    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] raw;
        int unsigned sel;
        int unsigned len;
        raw = {$urandom(), $urandom()};
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            return raw[EXP_W-1:0];
        end
        if (sel < 6) begin
            return '0;
        end
        len = $urandom_range(1, 12);
        raw = raw & ((64'd1 << len) - 64'd1);
        raw[len-1] = 1'b1;
        return raw[EXP_W-1:0];
    endfunction

    // Offer one item, hold it until the transfer, then maybe idle.
    task automatic send_item(input logic [MOD_W-1:0] base, input logic [EXP_W-1:0] expo);
        int unsigned gap;
        i_valid    <= 1'b1;
        i_base     <= base;
        i_exponent <= expo;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if (sent % 64 == 0) begin
            steady_tx = ($urandom_range(0, 3) == 0);
        end
        if (!steady_tx && $urandom_range(0, 99) >= 50) begin
            gap = idle_len();
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (rcvd < sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [MOD_W-1:0] value);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_modulus = value;
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_item(pick_base(), pick_exponent());
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off that
    // lets the block fill up while the sender keeps offering.
    initial begin
        int unsigned stall_left;
        bit          steady_rx;
        bit          held;
        stall_left = 0;
        steady_rx  = 1'b0;
        held       = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                rcvd++;
                if (rcvd % 64 == 0) begin
                    steady_rx = ($urandom_range(0, 3) == 0);
                end
                if (rcvd == HOLD_AT && !held) begin
                    held       = 1'b1;
                    stall_left = HOLD_CYCLES;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (steady_rx || $urandom_range(0, 99) < 60) begin
                i_stall <= 1'b0;
            end else begin
                stall_left = idle_len() - 1;
                i_stall <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles without any transfer on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_base        <= '0;
        i_exponent    <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_modulus <= '0;
        cur_modulus = MODULUS_RESET[MOD_W-1:0];

        // Extremes plus a few random modulus settings.
        settings[0] = '1;
        settings[1] = MOD_W'(1);
        settings[2] = MOD_W'(2);
        settings[3] = '0;
        settings[4] = MOD_W'(65521);
        settings[5] = MOD_W'($urandom());
        settings[6] = MOD_W'($urandom_range(3, 255));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset modulus.
        send_item('0, '0);                          // zero exponent gives 1
        send_item('1, '0);
        send_item('0, EXP_W'(1));
        send_item('1, EXP_W'(1));                   // base above modulus, reduced
        send_item(MOD_W'(1), '1);
        send_item('1, '1);                          // longest exponent, all ones
        send_item(MOD_W'(2), EXP_W'(1) << (EXP_W - 1));
        send_item(cur_modulus - MOD_W'(1), EXP_W'(2));
        send_item(MOD_W'(2), EXP_W'(30));
        send_item(MOD_W'(12345), EXP_W'({(EXP_W + 1) / 2{2'b01}}));
        send_item(MOD_W'({16{2'b10}}), EXP_W'({(EXP_W + 1) / 2{2'b10}}));

        send_random(FIRST_ITEMS);

        // Walk through the remaining settings, writing only while idle.
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            drain();
            write_modulus(settings[p]);
            send_item(MOD_W'($urandom()), '0);      // zero exponent, any modulus
            send_item(cur_modulus, EXP_W'(3));      // base equal to the modulus
            send_random(PHASE_ITEMS);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/mexp_pkg.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation.sv
hdl/mexp_checker.sv
dv/mexp_checker.sv
dv/tb_modular_exponentiation.sv
